FILE: rtl/core/ctlu_pkg.sv
// Shared types and constants for the chunked tile map lookup.
package ctlu_pkg;

	// Input command codes.
	typedef enum logic [1:0] {
		CMD_MAP_WR  = 2'd0,
		CMD_TILE_WR = 2'd1,
		CMD_LOOKUP  = 2'd2
	} cmd_t;

	// Field widths of the item format.
	localparam int FIELD_W = 10;
	localparam int TILE_W  = 10;
	localparam int COL_W   = 4;
	localparam int ROW_W   = 6;
	localparam int LEVEL_W = 4;
	localparam int SLOT_W  = 6;

	// Map layout: 64 surface superchunks of 256 entries, then 1024 entries per dungeon level.
	localparam int SURF_GROUPS      = 64;
	localparam int SURF_ENTRIES     = 256;
	localparam int SURF_MAP_DEPTH   = 16384;
	localparam int DUNGEON_MAP_SIZE = 1024;
	localparam int MAP_FULL_W       = 15;

	// Chunk store: 64 tile slots per chunk.
	localparam int CHUNK_SLOTS = 64;
	localparam int TILE_FULL_W = FIELD_W + SLOT_W;

	// Result queue behind the read pipeline.
	localparam int OUT_DEPTH = 4;
	localparam int OUT_PW    = 2;
	localparam int OUT_CW    = 3;

endpackage

FILE: rtl/core/ctlu_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
module ctlu_ram #(
	parameter int WIDTH = 10,
	parameter int DEPTH = 1024,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Read returns the old contents when the same entry is written in the same cycle.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: rtl/core/chunked_tilemap_lookup.sv
// A lookup result is offered from the result queue after its map read and chunk store read.
// Throughput: one item per cycle while in_ready; the map read feeds the chunk store read in the next cycle.
// Write commands take effect at their transfer and give no result.
// A four-entry result queue lets input continue while results wait for the consumer.
// Reset clears the pipeline and queue control only; both memories hold nothing defined
// until written, and no clearing pass runs.
module chunked_tilemap_lookup #(
	parameter int CHUNK_COUNT    = 1024,
	parameter int TILE_BITS      = 10,
	parameter int DUNGEON_LEVELS = 8
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [1:0]                     command,
	input  logic [ctlu_pkg::FIELD_W-1:0]   table_group,
	input  logic [ctlu_pkg::FIELD_W-1:0]   table_entry,
	input  logic [ctlu_pkg::FIELD_W-1:0]   table_value,
	input  logic [ctlu_pkg::FIELD_W-1:0]   world_x,
	input  logic [ctlu_pkg::FIELD_W-1:0]   world_y,
	input  logic [ctlu_pkg::LEVEL_W-1:0]   world_level,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [ctlu_pkg::TILE_W-1:0]    tile,
	output logic [ctlu_pkg::COL_W-1:0]     atlas_col,
	output logic [ctlu_pkg::ROW_W-1:0]     atlas_row
);

	localparam int MAP_DEPTH  = ctlu_pkg::SURF_MAP_DEPTH
		+ DUNGEON_LEVELS * ctlu_pkg::DUNGEON_MAP_SIZE;
	localparam int MAP_AW     = $clog2(MAP_DEPTH);
	localparam int TILE_DEPTH = CHUNK_COUNT * ctlu_pkg::CHUNK_SLOTS;
	localparam int TILE_AW    = $clog2(TILE_DEPTH);
	localparam int TW         = (TILE_BITS < ctlu_pkg::TILE_W) ? TILE_BITS : ctlu_pkg::TILE_W;

	ctlu_pkg::cmd_t cmd;
	logic in_xfer;
	logic out_xfer;
	logic lookup_xfer;

	logic                           map_we;
	logic [ctlu_pkg::MAP_FULL_W-1:0] map_wfull;
	logic [ctlu_pkg::MAP_FULL_W-1:0] map_rfull;
	logic [ctlu_pkg::FIELD_W-1:0]   map_rdata;
	logic                           level_bad;
	logic [ctlu_pkg::LEVEL_W-1:0]   level_m1;

	logic                            tile_we;
	logic [ctlu_pkg::TILE_FULL_W-1:0] tile_wfull;
	logic [ctlu_pkg::TILE_FULL_W-1:0] tile_rfull;
	logic [TW-1:0]                   tile_rdata;
	logic                            chunk_ok;

	logic                          lk_valid_s1;
	logic                          bad_s1;
	logic [ctlu_pkg::SLOT_W-1:0]   slot_s1;
	logic                          lk_valid_s2;
	logic                          zero_s2;
	logic [ctlu_pkg::TILE_W-1:0]   result_s2;

	logic [ctlu_pkg::TILE_W-1:0] res_q [ctlu_pkg::OUT_DEPTH];
	logic [ctlu_pkg::OUT_PW-1:0] wr_ptr_q;
	logic [ctlu_pkg::OUT_PW-1:0] rd_ptr_q;
	logic [ctlu_pkg::OUT_CW-1:0] cnt_q;
	logic [ctlu_pkg::OUT_CW-1:0] pending_q;

	// Handshake. Ready only depends on the count of lookups not yet delivered.
	assign cmd         = ctlu_pkg::cmd_t'(command);
	assign in_ready    = (pending_q != ctlu_pkg::OUT_CW'(ctlu_pkg::OUT_DEPTH));
	assign in_xfer     = in_valid && in_ready;
	assign out_xfer    = out_valid && out_ready;
	assign lookup_xfer = in_xfer && (cmd == ctlu_pkg::CMD_LOOKUP);

	// Write decode for both memories; out-of-range writes are dropped.
	always_comb begin
		map_we     = 1'b0;
		map_wfull  = '0;
		tile_we    = 1'b0;
		tile_wfull = {table_group, table_entry[ctlu_pkg::SLOT_W-1:0]};
		if ({1'b0, table_group} < 11'(ctlu_pkg::SURF_GROUPS)) begin
			map_wfull = {1'b0, table_group[5:0], table_entry[7:0]};
		end else begin
			// Dungeon region starts at the surface map size, one 1024-entry block per level.
			map_wfull = {2'b10, table_group[2:0], table_entry};
		end
		if (in_xfer) begin
			unique case (cmd)
				ctlu_pkg::CMD_MAP_WR: begin
					if ({1'b0, table_group} < 11'(ctlu_pkg::SURF_GROUPS)) begin
						map_we = ({2'b0, table_entry} < 12'(ctlu_pkg::SURF_ENTRIES));
					end else begin
						map_we = ({1'b0, table_group}
							< 11'(ctlu_pkg::SURF_GROUPS + DUNGEON_LEVELS));
					end
				end
				ctlu_pkg::CMD_TILE_WR: begin
					tile_we = ({1'b0, table_group} < 11'(CHUNK_COUNT))
						&& ({2'b0, table_entry} < 12'(ctlu_pkg::CHUNK_SLOTS));
				end
				default: begin
					map_we  = 1'b0;
					tile_we = 1'b0;
				end
			endcase
		end
	end

	// Lookup map address from the world position and level.
	assign level_m1  = world_level - ctlu_pkg::LEVEL_W'(1);
	assign level_bad = (world_level > ctlu_pkg::LEVEL_W'(DUNGEON_LEVELS));
	always_comb begin
		if (world_level == '0) begin
			map_rfull = {1'b0, world_y[9:7], world_x[9:7], world_y[6:3], world_x[6:3]};
		end else begin
			map_rfull = {2'b10, level_m1[2:0], world_y[7:3], world_x[7:3]};
		end
	end

	ctlu_ram #(
		.WIDTH (ctlu_pkg::FIELD_W),
		.DEPTH (MAP_DEPTH)
	) u_map_ram (
		.clk   (clk),
		.we    (map_we),
		.waddr (map_wfull[MAP_AW-1:0]),
		.wdata (table_value),
		.raddr (map_rfull[MAP_AW-1:0]),
		.rdata (map_rdata)
	);

	// Stage 1: the map read is in flight; keep the slot and the level check.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lk_valid_s1 <= 1'b0;
		end else begin
			lk_valid_s1 <= lookup_xfer;
		end
	end

	always_ff @(posedge clk) begin
		bad_s1  <= level_bad;
		slot_s1 <= {world_y[2:0], world_x[2:0]};
	end

	// Chunk number from the map selects the chunk store row.
	assign chunk_ok   = ({1'b0, map_rdata} < 11'(CHUNK_COUNT));
	assign tile_rfull = {map_rdata, slot_s1};

	ctlu_ram #(
		.WIDTH (TW),
		.DEPTH (TILE_DEPTH)
	) u_tile_ram (
		.clk   (clk),
		.we    (tile_we),
		.waddr (tile_wfull[TILE_AW-1:0]),
		.wdata (table_value[TW-1:0]),
		.raddr (tile_rfull[TILE_AW-1:0]),
		.rdata (tile_rdata)
	);

	// Stage 2: the tile read is in flight; a bad level or chunk forces a zero result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lk_valid_s2 <= 1'b0;
		end else begin
			lk_valid_s2 <= lk_valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		zero_s2 <= bad_s1 || !chunk_ok;
	end

	assign result_s2 = zero_s2 ? '0 : ctlu_pkg::TILE_W'(tile_rdata);

	// Result queue storage.
	always_ff @(posedge clk) begin
		if (lk_valid_s2) begin
			res_q[wr_ptr_q] <= result_s2;
		end
	end

	// Queue pointers, fill count and count of lookups not yet delivered.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q  <= '0;
			rd_ptr_q  <= '0;
			cnt_q     <= '0;
			pending_q <= '0;
		end else begin
			if (lk_valid_s2) begin
				wr_ptr_q <= wr_ptr_q + ctlu_pkg::OUT_PW'(1);
			end
			if (out_xfer) begin
				rd_ptr_q <= rd_ptr_q + ctlu_pkg::OUT_PW'(1);
			end
			case ({lk_valid_s2, out_xfer})
				2'b10:   cnt_q <= cnt_q + ctlu_pkg::OUT_CW'(1);
				2'b01:   cnt_q <= cnt_q - ctlu_pkg::OUT_CW'(1);
				default: cnt_q <= cnt_q;
			endcase
			case ({lookup_xfer, out_xfer})
				2'b10:   pending_q <= pending_q + ctlu_pkg::OUT_CW'(1);
				2'b01:   pending_q <= pending_q - ctlu_pkg::OUT_CW'(1);
				default: pending_q <= pending_q;
			endcase
		end
	end

	// Output fields come from the queue head.
	assign out_valid = (cnt_q != '0);
	assign tile      = res_q[rd_ptr_q];
	assign atlas_col = tile[ctlu_pkg::COL_W-1:0];
	assign atlas_row = tile[ctlu_pkg::TILE_W-1:ctlu_pkg::COL_W];

	// Lookups in flight never exceed the queue space reserved for them.
	a_pending_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q <= ctlu_pkg::OUT_CW'(ctlu_pkg::OUT_DEPTH))
		else $error("pending lookup count above queue depth");

	// The queue holds only results of lookups already counted as pending.
	a_queue_in_pending: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= pending_q)
		else $error("queue fill exceeds pending lookups");

	// A result leaving the read pipeline always finds room in the queue.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		lk_valid_s2 |-> (cnt_q < ctlu_pkg::OUT_CW'(ctlu_pkg::OUT_DEPTH)))
		else $error("result queue overflow");

	// An accepted lookup enters the map read stage on the next cycle.
	a_lookup_enters: assert property (@(posedge clk) disable iff (!arst_n)
		lookup_xfer |=> lk_valid_s1)
		else $error("accepted lookup missing from stage one");

endmodule
